// ===== sv/bpms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the mode button block.
// No dependencies; imported by every module of the block.
package bpms_pkg;

  localparam int unsigned NOW_W  = 32;
  localparam int unsigned MODE_W = 4;
  localparam int unsigned CFG_W  = 16;

  localparam logic [MODE_W-1:0] MODE_COUNT = 4'd6;  // top mode value means off

  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] HOLD_RST     = 16'd1000;

  // register indexes on the configuration port
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_HOLD     = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  // one classified sample, carried from front to back
  typedef struct packed {
    logic             level;
    logic [NOW_W-1:0] now;
    logic             sup;
    logic             fall;  // pressed now, released before
    logic             rise;  // released now, pressed before
  } smp_t;

  localparam int unsigned SMP_W = $bits(smp_t);

  function automatic logic [MODE_W-1:0] mode_adv(input logic [MODE_W-1:0] m);
    mode_adv = (m < MODE_COUNT) ? m + 4'd1 : 4'd1;
  endfunction

endpackage

// ===== sv/bpms_front.sv =====
`timescale 1ns / 1ps
// Front end: takes samples and tags level edges against the previous sample.
// Depends on bpms_pkg.
module bpms_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,   // [0] button_level, [32:1] now_ms, [33] suppress_actions
  input  logic               q_full,
  output logic               q_push,
  output bpms_pkg::smp_t     q_wdata
);
  import bpms_pkg::*;

  logic last_level_r, last_level_nxt;
  logic lvl;

  assign lvl       = in_tdata[0];
  assign in_tready = rst_n & ~q_full;
  assign q_push    = in_tvalid & in_tready;

  always_comb begin
    q_wdata.level = lvl;
    q_wdata.now   = in_tdata[NOW_W:1];
    q_wdata.sup   = in_tdata[NOW_W+1];
    q_wdata.fall  = ~lvl & last_level_r;
    q_wdata.rise  = lvl & ~last_level_r;
    last_level_nxt = q_push ? lvl : last_level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
    end else begin
      last_level_r <= last_level_nxt;
    end
  end

endmodule

// ===== sv/bpms_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified samples between front and back.
// Depends on bpms_pkg.
module bpms_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bpms_pkg::smp_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output bpms_pkg::smp_t rdata
);
  import bpms_pkg::*;

  smp_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == 2'd2);
  assign rvalid = (cnt_r != 2'd0);
  assign rdata  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/bpms_back.sv =====
`timescale 1ns / 1ps
// Back end: debounce timing, short/long press decisions, mode update, result register.
// Depends on bpms_pkg.
module bpms_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [bpms_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           q_rvalid,
  input  bpms_pkg::smp_t                 q_rdata,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [1:0]                     out_tuser,
  output logic [15:0]                    out_tdata
);
  import bpms_pkg::*;

  logic [CFG_W-1:0]  deb_r, deb_nxt, hold_r, hold_nxt;
  logic [NOW_W-1:0]  press_t_r, press_t_nxt, rel_t_r, rel_t_nxt;
  logic              long_r, long_nxt;
  logic [MODE_W-1:0] cur_r, cur_nxt, rem_r, rem_nxt;
  logic              ov_r, ov_nxt;
  ev_t               ev_r, ev_nxt;
  logic [MODE_W-1:0] mode_o_r, rem_o_r;
  logic              ind_r, ind_nxt, chg_r, chg_nxt;

  logic [NOW_W-1:0]  d_rel, d_press;
  logic              fall_ok, rise_ok, hold_hit;
  logic [MODE_W-1:0] m_tmp;

  assign q_pop      = q_rvalid & (~ov_r | out_tready);
  assign out_tvalid = ov_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {6'd0, chg_r, ind_r, rem_o_r, mode_o_r};

  assign d_rel    = q_rdata.now - rel_t_r;
  assign d_press  = q_rdata.now - press_t_r;
  assign fall_ok  = q_rdata.fall & (d_rel > {16'd0, deb_r});
  assign rise_ok  = q_rdata.rise & (d_press > {16'd0, deb_r});
  // hold is gated off on a counted press edge, which also sets press time to now
  assign hold_hit = ~q_rdata.level & ~fall_ok & (d_press > {16'd0, hold_r});

  always_comb begin
    deb_nxt     = deb_r;
    hold_nxt    = hold_r;
    press_t_nxt = press_t_r;
    rel_t_nxt   = rel_t_r;
    long_nxt    = long_r;
    cur_nxt     = cur_r;
    rem_nxt     = rem_r;
    ev_nxt      = EV_NONE;
    ind_nxt     = 1'b0;
    chg_nxt     = 1'b0;
    m_tmp       = cur_r;
    ov_nxt      = q_pop ? 1'b1 : (ov_r & ~out_tready);

    if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE: deb_nxt  = cfg_wdata;
        CFG_HOLD:     hold_nxt = cfg_wdata;
        default:      ;
      endcase
    end

    if (q_pop) begin
      if (fall_ok) begin
        press_t_nxt = q_rdata.now;
      end
      if (rise_ok) begin
        if (!long_r && !q_rdata.sup) begin
          if (cur_r == MODE_COUNT) begin
            // leaving off: restore, never back into off
            m_tmp = (rem_r == MODE_COUNT) ? mode_adv(rem_r) : rem_r;
          end else begin
            m_tmp   = mode_adv(cur_r);
            rem_nxt = m_tmp;
            ind_nxt = (m_tmp != MODE_COUNT);
          end
          cur_nxt = m_tmp;
          ev_nxt  = EV_SHORT;
          chg_nxt = (m_tmp != cur_r);
        end else begin
          long_nxt = 1'b0;
        end
        rel_t_nxt = q_rdata.now;
      end
      if (hold_hit) begin
        if (!q_rdata.sup) begin
          cur_nxt = MODE_COUNT;
          ev_nxt  = EV_LONG;
        end
        long_nxt    = 1'b1;
        press_t_nxt = q_rdata.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r     <= DEBOUNCE_RST;
      hold_r    <= HOLD_RST;
      press_t_r <= '0;
      rel_t_r   <= '0;
      long_r    <= 1'b0;
      cur_r     <= '0;
      rem_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      deb_r     <= deb_nxt;
      hold_r    <= hold_nxt;
      press_t_r <= press_t_nxt;
      rel_t_r   <= rel_t_nxt;
      long_r    <= long_nxt;
      cur_r     <= cur_nxt;
      rem_r     <= rem_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r     <= ev_nxt;
      mode_o_r <= cur_nxt;
      rem_o_r  <= rem_nxt;
      ind_r    <= ind_nxt;
      chg_r    <= chg_nxt;
    end
  end

  a_long_off: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ev_r == EV_LONG |-> mode_o_r == MODE_COUNT)
    else $error("long press result not in off mode");

  a_chg_short: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (chg_r || ind_r) |-> ev_r == EV_SHORT)
    else $error("mode change flagged without short press");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= MODE_COUNT && rem_r <= MODE_COUNT)
    else $error("mode state out of range");

  a_long_flag: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && hold_hit |=> long_r)
    else $error("hold did not mark long press");

endmodule

// ===== sv/button_press_mode_selector.sv =====
`timescale 1ns / 1ps
// Top level of the mode button block: front classifier, sample queue, back end.
// Depends on bpms_pkg, bpms_front, bpms_queue, bpms_back.
//
//  port group | direction | contents
//  in_*       | in        | tdata: button_level, now_ms, suppress_actions
//  out_*      | out       | tuser: press_event; tdata: mode, saved_mode, show_indicator, mode_changed
//  cfg_*      | in        | addr 0 debounce_ms, addr 1 hold_ms
//
// One sample per clock sustained while out_tready is high; an accepted sample is written into
// the queue, then decided into the result register.
// The two-entry queue lets the front take samples while the result register is stalled.
// Synchronous active-low reset; in_tready is low during reset.
module button_press_mode_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] button_level, [32:1] now_ms, [33] suppress_actions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] press_event
  output logic [15:0] out_tdata,  // [3:0] mode, [7:4] saved_mode, [8] show_indicator,
                                  // [9] mode_changed
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import bpms_pkg::*;

  logic q_push, q_full, q_pop, q_rvalid;
  smp_t q_wdata, q_rdata;

  bpms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bpms_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_rvalid),
    .rdata  (q_rdata)
  );

  bpms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_rvalid   (q_rvalid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
